// ===== hdl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg - shared types and constants for the magnetometer coverage monitor
// Register map, command codes, result field widths and register reset values.
// ----------------------------------------------------------------------------
package mcc_pkg;

   // Fixed field widths of the channels
   localparam int MAG_W     = 16;
   localparam int OCT_W     = 3;
   localparam int GOOD_W    = 4;
   localparam int COV_W     = 9;

   // Configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   // Register widths
   localparam int RANGE_THR_W = 16;
   localparam int MOVE_THR_W  = 32;
   localparam int SECT_W      = 10;
   localparam int SAMP_W      = 10;
   localparam int GAIN_W      = 24;

   // Fractional bits of range_gain
   localparam int GAIN_FRAC = 16;
   // Coverage weight of one covered octant and full-scale coverage
   localparam int OCT_WEIGHT_SHIFT = 5;
   localparam int COV_FULL         = 256;

   // Command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      RI_RANGE_THRESHOLD    = 3'd0,
      RI_MOVE_THRESHOLD_SQ  = 3'd1,
      RI_MIN_SECTOR_SAMPLES = 3'd2,
      RI_MIN_GOOD_SECTORS   = 3'd3,
      RI_MIN_SAMPLES        = 3'd4,
      RI_MAX_SAMPLES        = 3'd5,
      RI_RANGE_GAIN         = 3'd6
   } reg_index_type;

   // Register reset values
   localparam logic [RANGE_THR_W-1:0] RANGE_THR_RST = 16'd16;
   localparam logic [MOVE_THR_W-1:0]  MOVE_THR_RST  = 32'd0;
   localparam logic [SECT_W-1:0]      MIN_SECT_RST  = 10'd10;
   localparam logic [GOOD_W-1:0]      MIN_GOOD_RST  = 4'd4;
   localparam logic [SAMP_W-1:0]      MIN_SAMP_RST  = 10'd300;
   localparam logic [SAMP_W-1:0]      MAX_SAMP_RST  = 10'd600;
   localparam logic [GAIN_W-1:0]      GAIN_RST      = 24'd174763;

endpackage

// ===== hdl/mcc_if.sv =====
// ----------------------------------------------------------------------------
// mcc_if - item channels of the magnetometer coverage monitor
// Sample/command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcc_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic                          cmd;
   logic signed [SAMPLE_BITS-1:0] mag_x;
   logic signed [SAMPLE_BITS-1:0] mag_y;
   logic signed [SAMPLE_BITS-1:0] mag_z;

   modport source (output valid, cmd, mag_x, mag_y, mag_z, input ready);
   modport sink   (input valid, cmd, mag_x, mag_y, mag_z, output ready);
endinterface

interface mcc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mcc_pkg::OCT_W-1:0]    octant;
   logic                         moving;
   logic [mcc_pkg::GOOD_W-1:0]   covered_octants;
   logic [mcc_pkg::COV_W-1:0]    coverage_q8;
   logic                         coverage_ok;
   logic                         ready_res;
   logic                         full_res;

   modport source (output valid, octant, moving, covered_octants, coverage_q8,
                   coverage_ok, ready_res, full_res, input ready);
   modport sink   (input valid, octant, moving, covered_octants, coverage_q8,
                   coverage_ok, ready_res, full_res, output ready);
endinterface

// ===== hdl/mag_calibration_coverage.sv =====
// ----------------------------------------------------------------------------
// mag_calibration_coverage - magnetometer calibration coverage monitor
// Tracks per-axis min/max, detects movement, bins moving samples by octant
// and reports coverage, ok, ready and full flags for every item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, the statistics
//   update stage and the coverage/result register before result valid.
// Throughput: one item per cycle; the three stages advance together and
//   stall only when a result sits unclaimed on rsp_ch.
// Reset (synchronous, active high): registers return to their defaults,
//   statistics are emptied in the same cycle; no clearing pass.
// ----------------------------------------------------------------------------
module mag_calibration_coverage #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   mcc_req_if.sink                           req_ch,
   mcc_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mcc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mcc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mcc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   // ------------------------------------------------------------------------
   // Derived widths
   // ------------------------------------------------------------------------
   localparam int S    = SAMPLE_BITS;
   localparam int SP   = S + 1;                 // difference / span
   localparam int CMPW2 = S + 2;                // octant compare
   localparam int DW   = 2 * S + 3;             // squared step sum
   localparam int CMPW = (DW > mcc_pkg::MOVE_THR_W) ? DW : mcc_pkg::MOVE_THR_W;
   localparam int CW   = (COUNT_BITS > mcc_pkg::SAMP_W) ? COUNT_BITS : mcc_pkg::SAMP_W;
   localparam int SUMW = S + 3;                 // sum of three spans
   localparam int PW   = SUMW + mcc_pkg::GAIN_W + 1;
   localparam int RW   = PW - mcc_pkg::GAIN_FRAC;
   localparam int TW   = RW + 1;

   localparam logic signed [S-1:0]          SMAXV   = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0]          SMINV   = {1'b1, {(S-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0]        CTR_MAX = {COUNT_BITS{1'b1}};

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [mcc_pkg::RANGE_THR_W-1:0] range_thr_ff;
   logic [mcc_pkg::MOVE_THR_W-1:0]  move_thr_ff;
   logic [mcc_pkg::SECT_W-1:0]      min_sect_ff;
   logic [mcc_pkg::GOOD_W-1:0]      min_good_ff;
   logic [mcc_pkg::SAMP_W-1:0]      min_samp_ff;
   logic [mcc_pkg::SAMP_W-1:0]      max_samp_ff;
   logic [mcc_pkg::GAIN_W-1:0]      gain_ff;

   logic                            csr_wr;
   mcc_pkg::reg_index_type          csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = mcc_pkg::reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         range_thr_ff <= mcc_pkg::RANGE_THR_RST;
         move_thr_ff  <= mcc_pkg::MOVE_THR_RST;
         min_sect_ff  <= mcc_pkg::MIN_SECT_RST;
         min_good_ff  <= mcc_pkg::MIN_GOOD_RST;
         min_samp_ff  <= mcc_pkg::MIN_SAMP_RST;
         max_samp_ff  <= mcc_pkg::MAX_SAMP_RST;
         gain_ff      <= mcc_pkg::GAIN_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            mcc_pkg::RI_RANGE_THRESHOLD:    range_thr_ff <= pwdata[mcc_pkg::RANGE_THR_W-1:0];
            mcc_pkg::RI_MOVE_THRESHOLD_SQ:  move_thr_ff  <= pwdata[mcc_pkg::MOVE_THR_W-1:0];
            mcc_pkg::RI_MIN_SECTOR_SAMPLES: min_sect_ff  <= pwdata[mcc_pkg::SECT_W-1:0];
            mcc_pkg::RI_MIN_GOOD_SECTORS:   min_good_ff  <= pwdata[mcc_pkg::GOOD_W-1:0];
            mcc_pkg::RI_MIN_SAMPLES:        min_samp_ff  <= pwdata[mcc_pkg::SAMP_W-1:0];
            mcc_pkg::RI_MAX_SAMPLES:        max_samp_ff  <= pwdata[mcc_pkg::SAMP_W-1:0];
            mcc_pkg::RI_RANGE_GAIN:         gain_ff      <= pwdata[mcc_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mcc_pkg::RI_RANGE_THRESHOLD:    prdata = mcc_pkg::CSR_DATA_W'(range_thr_ff);
         mcc_pkg::RI_MOVE_THRESHOLD_SQ:  prdata = mcc_pkg::CSR_DATA_W'(move_thr_ff);
         mcc_pkg::RI_MIN_SECTOR_SAMPLES: prdata = mcc_pkg::CSR_DATA_W'(min_sect_ff);
         mcc_pkg::RI_MIN_GOOD_SECTORS:   prdata = mcc_pkg::CSR_DATA_W'(min_good_ff);
         mcc_pkg::RI_MIN_SAMPLES:        prdata = mcc_pkg::CSR_DATA_W'(min_samp_ff);
         mcc_pkg::RI_MAX_SAMPLES:        prdata = mcc_pkg::CSR_DATA_W'(max_samp_ff);
         mcc_pkg::RI_RANGE_GAIN:         prdata = mcc_pkg::CSR_DATA_W'(gain_ff);
         default:                        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Pipeline control: the three stages move as one. adv is the shared
   // enable; the input register also fills when it is empty.
   // ------------------------------------------------------------------------
   logic adv;
   logic req_fire;
   logic proc_fire;

   logic                  in_valid_ff;
   logic                  in_cmd_ff;
   logic signed [S-1:0]   in_mag_ff [3];

   logic                  mid_valid_ff;
   logic [mcc_pkg::OCT_W-1:0] mid_oct_ff;
   logic                  mid_moving_ff;

   logic                  rsp_valid_ff;

   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || adv;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign proc_fire    = in_valid_ff && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) in_valid_ff <= req_ch.valid;
         if (adv) begin
            mid_valid_ff <= in_valid_ff;
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   // Input register: sample or clear command, taken as S-bit two's complement
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff    <= req_ch.cmd;
         in_mag_ff[0] <= S'(req_ch.mag_x);
         in_mag_ff[1] <= S'(req_ch.mag_y);
         in_mag_ff[2] <= S'(req_ch.mag_z);
      end
   end

   // ------------------------------------------------------------------------
   // Statistics state
   // ------------------------------------------------------------------------
   logic signed [S-1:0]     axis_min_ff [3];
   logic signed [S-1:0]     axis_max_ff [3];
   logic signed [S-1:0]     last_ff     [3];
   logic                    first_pending_ff;
   logic [COUNT_BITS-1:0]   oct_cnt_ff  [8];
   logic [COUNT_BITS-1:0]   sample_cnt_ff;

   logic signed [S-1:0]     axis_min_in [3];
   logic signed [S-1:0]     axis_max_in [3];
   logic [COUNT_BITS-1:0]   oct_cnt_in  [8];
   logic [COUNT_BITS-1:0]   sample_cnt_in;

   // ------------------------------------------------------------------------
   // Update stage: min/max, octant of the updated box, step length test
   // ------------------------------------------------------------------------
   logic signed [SP-1:0]      step     [3];
   logic signed [2*SP-1:0]    step_sq  [3];
   logic [DW-1:0]             step_dist;
   logic                      moving_in;
   logic [mcc_pkg::OCT_W-1:0] oct_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         axis_min_in[i] = (in_mag_ff[i] < axis_min_ff[i]) ? in_mag_ff[i] : axis_min_ff[i];
         axis_max_in[i] = (in_mag_ff[i] > axis_max_ff[i]) ? in_mag_ff[i] : axis_max_ff[i];
         // 2*s > max + min, with the box already stretched by this sample
         oct_in[i] = (CMPW2'(in_mag_ff[i]) <<< 1) >
                     (CMPW2'(axis_max_in[i]) + CMPW2'(axis_min_in[i]));
         step[i]    = SP'(in_mag_ff[i]) - SP'(last_ff[i]);
         step_sq[i] = step[i] * step[i];
      end
      // squares are non-negative and below 2^(2S)+1
      step_dist = DW'(step_sq[0][2*S:0]) + DW'(step_sq[1][2*S:0]) + DW'(step_sq[2][2*S:0]);
      moving_in = !first_pending_ff && (CMPW'(step_dist) > CMPW'(move_thr_ff));

      // one saturating counter per octant, bumped only by a moving sample
      for (int k = 0; k < 8; k++) begin
         oct_cnt_in[k] = oct_cnt_ff[k];
         if (moving_in && (oct_in == mcc_pkg::OCT_W'(k)) && (oct_cnt_ff[k] != CTR_MAX))
            oct_cnt_in[k] = oct_cnt_ff[k] + 1'b1;
      end
      sample_cnt_in = (sample_cnt_ff != CTR_MAX) ? sample_cnt_ff + 1'b1 : sample_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            axis_min_ff[i] <= SMAXV;
            axis_max_ff[i] <= SMINV;
            last_ff[i]     <= '0;
         end
         for (int k = 0; k < 8; k++) oct_cnt_ff[k] <= '0;
         first_pending_ff <= 1'b1;
         sample_cnt_ff    <= '0;
      end else if (proc_fire) begin
         if (in_cmd_ff == mcc_pkg::CMD_CLEAR) begin
            for (int i = 0; i < 3; i++) begin
               axis_min_ff[i] <= SMAXV;
               axis_max_ff[i] <= SMINV;
               last_ff[i]     <= '0;
            end
            for (int k = 0; k < 8; k++) oct_cnt_ff[k] <= '0;
            first_pending_ff <= 1'b1;
            sample_cnt_ff    <= '0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               axis_min_ff[i] <= axis_min_in[i];
               axis_max_ff[i] <= axis_max_in[i];
               last_ff[i]     <= in_mag_ff[i];
            end
            for (int k = 0; k < 8; k++) oct_cnt_ff[k] <= oct_cnt_in[k];
            first_pending_ff <= 1'b0;
            sample_cnt_ff    <= sample_cnt_in;
         end
      end
   end

   // per-item fields; a clear reports octant 0, not moving
   always_ff @(posedge clock) begin
      if (proc_fire) begin
         if (in_cmd_ff == mcc_pkg::CMD_CLEAR) begin
            mid_oct_ff    <= '0;
            mid_moving_ff <= 1'b0;
         end else begin
            mid_oct_ff    <= oct_in;
            mid_moving_ff <= moving_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Coverage stage. While an item sits in the mid stage the statistics
   // registers hold exactly the state that item left, since the stages move
   // together.
   // ------------------------------------------------------------------------
   logic [mcc_pkg::GOOD_W-1:0] good;
   logic signed [SP-1:0]       span [3];
   logic signed [SUMW-1:0]     span_sum;
   logic signed [PW-1:0]       prod;
   logic signed [RW-1:0]       rpart;
   logic signed [TW-1:0]       total;
   logic [mcc_pkg::COV_W-1:0]  cov;
   logic                       range_ok;
   logic                       cov_ok;

   always_comb begin
      good = '0;
      for (int k = 0; k < 8; k++)
         if (CW'(oct_cnt_ff[k]) >= CW'(min_sect_ff))
            good = good + 1'b1;

      range_ok = 1'b1;
      span_sum = '0;
      for (int i = 0; i < 3; i++) begin
         span[i]  = SP'(axis_max_ff[i]) - SP'(axis_min_ff[i]);
         span_sum = span_sum + SUMW'(span[i]);
         if (!(span[i] > $signed({1'b0, range_thr_ff})))
            range_ok = 1'b0;
      end

      // floor(span_sum * gain / 2^16): arithmetic shift rounds toward -inf
      prod  = PW'(span_sum) * PW'($signed({1'b0, gain_ff}));
      rpart = prod[PW-1:mcc_pkg::GAIN_FRAC];
      total = TW'(rpart) +
              TW'($signed({1'b0, good, {mcc_pkg::OCT_WEIGHT_SHIFT{1'b0}}}));
      if (total < 0)
         cov = '0;
      else if (total > TW'(mcc_pkg::COV_FULL))
         cov = mcc_pkg::COV_W'(mcc_pkg::COV_FULL);
      else
         cov = total[mcc_pkg::COV_W-1:0];

      cov_ok = range_ok && (good >= min_good_ff);
   end

   // Result register
   logic [mcc_pkg::OCT_W-1:0]  rsp_oct_ff;
   logic                       rsp_moving_ff;
   logic [mcc_pkg::GOOD_W-1:0] rsp_good_ff;
   logic [mcc_pkg::COV_W-1:0]  rsp_cov_ff;
   logic                       rsp_ok_ff;
   logic                       rsp_ready_ff;
   logic                       rsp_full_ff;

   always_ff @(posedge clock) begin
      if (adv && mid_valid_ff) begin
         rsp_oct_ff    <= mid_oct_ff;
         rsp_moving_ff <= mid_moving_ff;
         rsp_good_ff   <= good;
         rsp_cov_ff    <= cov;
         rsp_ok_ff     <= cov_ok;
         rsp_ready_ff  <= cov_ok && (CW'(sample_cnt_ff) >= CW'(min_samp_ff));
         rsp_full_ff   <= CW'(sample_cnt_ff) >= CW'(max_samp_ff);
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.octant          = rsp_oct_ff;
   assign rsp_ch.moving          = rsp_moving_ff;
   assign rsp_ch.covered_octants = rsp_good_ff;
   assign rsp_ch.coverage_q8     = rsp_cov_ff;
   assign rsp_ch.coverage_ok     = rsp_ok_ff;
   assign rsp_ch.ready_res       = rsp_ready_ff;
   assign rsp_ch.full_res        = rsp_full_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The first-sample flag and the sample counter are cleared and set together
   a_first_vs_count: assert property (@(posedge clock) disable iff (reset)
      first_pending_ff == (sample_cnt_ff == '0))
      else $error("first-sample flag out of step with sample count");

   // Once a sample has been seen the box is never inverted
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (sample_cnt_ff != '0) |-> (axis_min_ff[0] <= axis_max_ff[0]) &&
                                (axis_min_ff[1] <= axis_max_ff[1]) &&
                                (axis_min_ff[2] <= axis_max_ff[2]))
      else $error("axis min above axis max after a sample");

   // The sample counter only drops on a clear command
   a_count_monotone: assert property (@(posedge clock) disable iff (reset)
      !(proc_fire && (in_cmd_ff == mcc_pkg::CMD_CLEAR)) |=>
         (sample_cnt_ff >= $past(sample_cnt_ff)))
      else $error("sample count fell without a clear");

   // A stalled item in the update stage is not lost
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && !adv) |=> mid_valid_ff)
      else $error("item dropped from update stage during stall");

   // A sample never counts as moving while the first-sample flag is set
   a_moving_binned: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && (in_cmd_ff == mcc_pkg::CMD_SAMPLE) && moving_in) |->
         !first_pending_ff)
      else $error("first sample after clear flagged as moving");

endmodule
